[rtl/gps_pkg.sv]
package gps_pkg;

  localparam int VAL_W      = 16;
  localparam int CNT_W      = 11;
  localparam int COORD_BITS = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // product widths; quotients are known to fit in COORD_BITS
  localparam int CPROD_W = CNT_W + COORD_BITS;
  localparam int RPROD_W = VAL_W + COORD_BITS;
  localparam int STEP_W  = $clog2(COORD_BITS);

endpackage

[rtl/graph_polyline_scaler.sv]
// channel  | direction | ports                                  | word
// ---------+-----------+----------------------------------------+----------------------------
// in       | sink      | in_valid, in_ready, in_sample_value    | one signed sample
// out      | source    | out_valid, out_ready, out_*            | one segment, final flag
// cfg      | sink      | cfg_valid, cfg_ready, cfg_index/data   | one register write
//
// A sample passes through accept, a shift-add multiply, a restoring divide (one quotient
// bit per cycle, column and row units side by side) and a finish step.
// With an invalid configuration a sample is consumed in its accept cycle.
// Finish waits while the output holds an untaken segment, except on a graph's first point.
// rst_n is synchronous; it clears the config registers, graph index and control state.
module graph_polyline_scaler
  import gps_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_sample_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_start_col,
  output logic [COORD_BITS-1:0]   out_start_row,
  output logic [COORD_BITS-1:0]   out_end_col,
  output logic [COORD_BITS-1:0]   out_end_row,
  output logic                    out_final_segment,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int CLAMP = (MAX_POINTS < (2 ** CNT_W) - 1) ? MAX_POINTS : (2 ** CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_CLAMP = CNT_W'(CLAMP);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_BITS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd6;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]              state_r;
  logic [STEP_W-1:0]       step_r;

  logic signed [VAL_W-1:0] vmin_r, vmax_r;
  logic [COORD_BITS-1:0]   left_r, top_r, right_r, bottom_r;
  logic [CNT_W-1:0]        count_r;

  logic [IDX_W-1:0]        point_index_r, cur_idx_r;
  logic                    last_r;
  logic [COORD_BITS-1:0]   prev_col_r, prev_row_r;

  logic [CPROD_W-1:0]      cmul_a_r, cacc_r, cdiv_r;
  logic [COORD_BITS-1:0]   cmul_b_r, cq_r;
  logic [RPROD_W-1:0]      rmul_a_r, racc_r, rdiv_r;
  logic [COORD_BITS-1:0]   rmul_b_r, rq_r;

  logic                    out_valid_r, out_final_r;
  logic [COORD_BITS-1:0]   out_sc_r, out_sr_r, out_ec_r, out_er_r;

  logic [CNT_W-1:0]        cnt_eff, cnt_m1;
  logic                    cfg_ok;
  logic [IDX_W-1:0]        idx_cur;
  logic signed [VAL_W-1:0] v_clamp;
  logic [VAL_W-1:0]        off, range;
  logic                    cge, rge;
  logic [COORD_BITS-1:0]   col_nxt, row_nxt;
  logic [IDX_W-1:0]        point_index_nxt;
  logic                    out_free;
  logic                    fin_go, seg_emit;

  always_comb begin
    cnt_eff = (count_r > CNT_CLAMP) ? CNT_CLAMP : count_r;
    cnt_m1  = cnt_eff - CNT_W'(1);
    cfg_ok  = (cnt_eff >= CNT_W'(2)) && (vmax_r > vmin_r) &&
              (right_r > left_r) && (bottom_r > top_r);
    idx_cur = (CW'(point_index_r) >= CW'(cnt_eff)) ? '0 : point_index_r;
    if (in_sample_value < vmin_r) begin
      v_clamp = vmin_r;
    end else if (in_sample_value > vmax_r) begin
      v_clamp = vmax_r;
    end else begin
      v_clamp = in_sample_value;
    end
    off   = VAL_W'(v_clamp - vmin_r);
    range = VAL_W'(vmax_r - vmin_r);
    cge   = cacc_r >= cdiv_r;
    rge   = racc_r >= rdiv_r;
    col_nxt = left_r + cq_r;
    row_nxt = bottom_r - rq_r;
    point_index_nxt = last_r ? '0 : cur_idx_r + IDX_W'(1);
    out_free = !out_valid_r || out_ready;
    fin_go   = (cur_idx_r == '0) || out_free;
    seg_emit = (state_r == ST_FIN) && fin_go && (cur_idx_r != '0);
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_start_col     = out_sc_r;
  assign out_start_row     = out_sr_r;
  assign out_end_col       = out_ec_r;
  assign out_end_row       = out_er_r;
  assign out_final_segment = out_final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmin_r   <= '0;
      vmax_r   <= '0;
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
      count_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VALUE_MIN:   vmin_r   <= cfg_data;
        REG_VALUE_MAX:   vmax_r   <= cfg_data;
        REG_BOX_LEFT:    left_r   <= cfg_data[COORD_BITS-1:0];
        REG_BOX_TOP:     top_r    <= cfg_data[COORD_BITS-1:0];
        REG_BOX_RIGHT:   right_r  <= cfg_data[COORD_BITS-1:0];
        REG_BOX_BOTTOM:  bottom_r <= cfg_data[COORD_BITS-1:0];
        REG_POINT_COUNT: count_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      point_index_r <= '0;
      prev_col_r    <= '0;
      prev_row_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (seg_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!cfg_ok) begin
              point_index_r <= '0;
            end else begin
              cur_idx_r <= idx_cur;
              last_r    <= (CW'(idx_cur) == CW'(cnt_m1));
              cmul_a_r  <= CPROD_W'(CNT_W'(idx_cur));
              cmul_b_r  <= right_r - left_r;
              cacc_r    <= '0;
              cdiv_r    <= CPROD_W'({cnt_m1, {(COORD_BITS-1){1'b0}}});
              rmul_a_r  <= RPROD_W'(off);
              rmul_b_r  <= bottom_r - top_r;
              racc_r    <= '0;
              rdiv_r    <= RPROD_W'({range, {(COORD_BITS-1){1'b0}}});
              step_r    <= '0;
              state_r   <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (cmul_b_r[0]) begin
            cacc_r <= cacc_r + cmul_a_r;
          end
          if (rmul_b_r[0]) begin
            racc_r <= racc_r + rmul_a_r;
          end
          cmul_a_r <= cmul_a_r << 1;
          cmul_b_r <= cmul_b_r >> 1;
          rmul_a_r <= rmul_a_r << 1;
          rmul_b_r <= rmul_b_r >> 1;
          if (step_r == STEP_LAST) begin
            step_r  <= '0;
            state_r <= ST_DIV;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_DIV: begin
          if (cge) begin
            cacc_r <= cacc_r - cdiv_r;
          end
          if (rge) begin
            racc_r <= racc_r - rdiv_r;
          end
          cq_r   <= {cq_r[COORD_BITS-2:0], cge};
          rq_r   <= {rq_r[COORD_BITS-2:0], rge};
          cdiv_r <= cdiv_r >> 1;
          rdiv_r <= rdiv_r >> 1;
          if (step_r == STEP_LAST) begin
            step_r  <= '0;
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            if (seg_emit) begin
              out_sc_r    <= prev_col_r;
              out_sr_r    <= prev_row_r;
              out_ec_r    <= col_nxt;
              out_er_r    <= row_nxt;
              out_final_r <= last_r;
            end
            prev_col_r    <= col_nxt;
            prev_row_r    <= row_nxt;
            point_index_r <= point_index_nxt;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/gps_checker.sv]
module gps_checker
  import gps_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_start_col,
  input logic [COORD_BITS-1:0] out_start_row,
  input logic [COORD_BITS-1:0] out_end_col,
  input logic [COORD_BITS-1:0] out_end_row,
  input logic                  out_final_segment
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_col) &&
      $stable(out_start_row) && $stable(out_end_col) && $stable(out_end_row) &&
      $stable(out_final_segment))
    else $error("segment word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a fresh sample needs the full multiply and divide before any result
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("segment appeared right after a sample was taken");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("segment appeared while the block was idle");

endmodule

bind graph_polyline_scaler gps_checker u_gps_checker (.*);

[test/tb_graph_polyline_scaler.sv]
`timescale 1ns / 1ps

module tb_graph_polyline_scaler;
  import gps_pkg::*;

  localparam int MAX_PTS    = 1024;
  localparam int RND_ITEMS  = 550;
  localparam int IDLE_PAD   = 30;
  localparam int LONG_HOLD  = 300;
  localparam int CYC_LIMIT  = 200000;
  localparam int DRAIN_MAX  = 5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VMIN, REG_VMAX, REG_LEFT, REG_TOP, REG_RIGHT, REG_BOTTOM, REG_COUNT, REG_UNUSED
  } cfg_reg_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_NONE, ROW_SEG} row_kind_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_col;
    logic [COORD_BITS-1:0] start_row;
    logic [COORD_BITS-1:0] end_col;
    logic [COORD_BITS-1:0] end_row;
    logic                  final_seg;
  } seg_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              addr;
    logic [CFG_DATA_W-1:0] data;
    seg_t                  seg;
  } dir_row_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] vmin;
    logic signed [VAL_W-1:0] vmax;
    logic [COORD_BITS-1:0]   left;
    logic [COORD_BITS-1:0]   top;
    logic [COORD_BITS-1:0]   right;
    logic [COORD_BITS-1:0]   bottom;
    logic [CNT_W-1:0]        count;
  } plot_cfg_t;

  localparam seg_t NO_SEG = '0;

  localparam int DIR_N = 42;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // zero registers: samples are swallowed
    '{ROW_NONE, REG_UNUSED, 16'd100,  NO_SEG},
    '{ROW_NONE, REG_UNUSED, 16'hFFFF, NO_SEG},
    '{ROW_CFG,  REG_VMIN,   16'd0,    NO_SEG},
    '{ROW_CFG,  REG_VMAX,   16'd255,  NO_SEG},
    '{ROW_CFG,  REG_LEFT,   16'd0,    NO_SEG},
    '{ROW_CFG,  REG_TOP,    16'd0,    NO_SEG},
    '{ROW_CFG,  REG_RIGHT,  16'd255,  NO_SEG},
    '{ROW_CFG,  REG_BOTTOM, 16'd255,  NO_SEG},
    '{ROW_CFG,  REG_COUNT,  16'd2,    NO_SEG},
    '{ROW_CFG,  REG_UNUSED, 16'hFFFF, NO_SEG},
    '{ROW_NONE, REG_UNUSED, 16'd0,    NO_SEG},
    '{ROW_SEG,  REG_UNUSED, 16'd255,  '{8'd0, 8'd255, 8'd255, 8'd0, 1'b1}},
    // clamped below and above
    '{ROW_NONE, REG_UNUSED, 16'h8000, NO_SEG},
    '{ROW_SEG,  REG_UNUSED, 16'h7FFF, '{8'd0, 8'd255, 8'd255, 8'd0, 1'b1}},
    '{ROW_CFG,  REG_VMIN,   16'h8000, NO_SEG},
    '{ROW_CFG,  REG_VMAX,   16'h7FFF, NO_SEG},
    '{ROW_CFG,  REG_RIGHT,  16'd254,  NO_SEG},
    '{ROW_CFG,  REG_COUNT,  16'd3,    NO_SEG},
    '{ROW_NONE, REG_UNUSED, 16'h8000, NO_SEG},
    '{ROW_SEG,  REG_UNUSED, 16'd0,    '{8'd0, 8'd255, 8'd127, 8'd128, 1'b0}},
    '{ROW_SEG,  REG_UNUSED, 16'h7FFF, '{8'd127, 8'd128, 8'd254, 8'd0, 1'b1}},
    // count lowered mid graph
    '{ROW_CFG,  REG_COUNT,  16'd5,    NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'd1000, NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'hFC18, NO_SEG},
    '{ROW_CFG,  REG_COUNT,  16'd2,    NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'd5,    NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'd6,    NO_SEG},
    // count above the maximum
    '{ROW_CFG,  REG_COUNT,  16'd2047, NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'h1234, NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'hEDCB, NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'h0001, NO_SEG},
    // an invalid value range, box width and box height in turn, then a fresh graph
    '{ROW_CFG,  REG_VMAX,   16'h8000, NO_SEG},
    '{ROW_NONE, REG_UNUSED, 16'd77,   NO_SEG},
    '{ROW_CFG,  REG_VMAX,   16'h7FFF, NO_SEG},
    '{ROW_CFG,  REG_RIGHT,  16'd0,    NO_SEG},
    '{ROW_NONE, REG_UNUSED, 16'd78,   NO_SEG},
    '{ROW_CFG,  REG_RIGHT,  16'd255,  NO_SEG},
    '{ROW_CFG,  REG_TOP,    16'd255,  NO_SEG},
    '{ROW_NONE, REG_UNUSED, 16'd79,   NO_SEG},
    '{ROW_CFG,  REG_TOP,    16'd0,    NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'd42,   NO_SEG},
    '{ROW_PRED, REG_UNUSED, 16'd43,   NO_SEG}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [VAL_W-1:0]      in_sample_value;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [COORD_BITS-1:0]        out_start_col;
  logic [COORD_BITS-1:0]        out_start_row;
  logic [COORD_BITS-1:0]        out_end_col;
  logic [COORD_BITS-1:0]        out_end_row;
  logic                         out_final_segment;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  plot_cfg_t             plot_cfg;
  logic [9:0]            pt_idx;
  logic [COORD_BITS-1:0] last_col;
  logic [COORD_BITS-1:0] last_row;

  seg_t     pending_segs[$];
  seg_t     rx_want;
  int       err_cnt = 0;
  int       cyc_cnt = 0;
  int       smp_lo, smp_hi;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_left = 0;
  int       stretch_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  graph_polyline_scaler #(.MAX_POINTS(MAX_PTS)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_start_col    (out_start_col),
    .out_start_row    (out_start_row),
    .out_end_col      (out_end_col),
    .out_end_row      (out_end_row),
    .out_final_segment(out_final_segment),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic plot_sample(input logic signed [VAL_W-1:0] v, output bit made,
                             output seg_t seg);
    int unsigned cnt, idx, pw, ph, rng, off, col, row;
    int lo, hi, s;
    bit last;
    cnt  = plot_cfg.count;
    lo   = plot_cfg.vmin;
    hi   = plot_cfg.vmax;
    s    = v;
    made = 1'b0;
    seg  = NO_SEG;
    if (cnt > MAX_PTS) cnt = MAX_PTS;
    if (cnt < 2 || hi <= lo || plot_cfg.right <= plot_cfg.left ||
        plot_cfg.bottom <= plot_cfg.top) begin
      pt_idx = '0;
      return;
    end
    idx = pt_idx;
    if (idx >= cnt) idx = 0;
    if (s < lo) s = lo;
    if (s > hi) s = hi;
    pw   = plot_cfg.right - plot_cfg.left;
    ph   = plot_cfg.bottom - plot_cfg.top;
    rng  = hi - lo;
    off  = s - lo;
    col  = plot_cfg.left + (idx * pw) / (cnt - 1);
    row  = plot_cfg.bottom - (off * ph) / rng;
    last = (idx == cnt - 1);
    made = (idx > 0);
    seg  = '{last_col, last_row, col[COORD_BITS-1:0], row[COORD_BITS-1:0], last};
    last_col = col[COORD_BITS-1:0];
    last_row = row[COORD_BITS-1:0];
    pt_idx   = last ? 10'd0 : 10'(idx + 1);
  endtask

  task automatic cfg_write(input cfg_reg_t addr, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= addr;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      REG_VMIN:   plot_cfg.vmin   = val;
      REG_VMAX:   plot_cfg.vmax   = val;
      REG_LEFT:   plot_cfg.left   = val[COORD_BITS-1:0];
      REG_TOP:    plot_cfg.top    = val[COORD_BITS-1:0];
      REG_RIGHT:  plot_cfg.right  = val[COORD_BITS-1:0];
      REG_BOTTOM: plot_cfg.bottom = val[COORD_BITS-1:0];
      REG_COUNT:  plot_cfg.count  = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [VAL_W-1:0] v, input row_kind_t how,
                             input seg_t typed);
    bit made;
    seg_t seg;
    if (cfg_valid) cfg_valid <= 1'b0;
    in_valid        <= 1'b1;
    in_sample_value <= v;
    do @(posedge clk); while (!in_ready);
    plot_sample(v, made, seg);
    if (how == ROW_SEG) pending_segs.push_back(typed);
    else if (how == ROW_PRED && made) pending_segs.push_back(seg);
  endtask

  task automatic in_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // block is idle once nothing is pending and the last word has cleared the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic new_setup(input bit keep_valid, output bit ok);
    int lo, hi, l, r, tp, bt, cnt, pick, t;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      lo = -32768;
      hi = 32767;
    end else if (pick == 1) begin
      lo = int'($urandom_range(0, 65531)) - 32768;
      hi = lo + int'($urandom_range(1, 4));
    end else begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      hi = int'($urandom_range(0, 65535)) - 32768;
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      if (lo == hi) begin
        if (hi < 32767) hi++;
        else lo--;
      end
    end
    if (pick == 0) begin
      l  = 0;
      r  = 255;
      tp = 0;
      bt = 255;
    end else begin
      l  = $urandom_range(0, 200);
      r  = $urandom_range(l + 1, 255);
      tp = $urandom_range(0, 200);
      bt = $urandom_range(tp + 1, 255);
    end
    t = $urandom_range(0, 19);
    if (t < 15)       cnt = $urandom_range(2, 10);
    else if (t < 17)  cnt = $urandom_range(11, 64);
    else if (t == 17) cnt = MAX_PTS;
    else if (t == 18) cnt = $urandom_range(MAX_PTS + 1, 2047);
    else              cnt = $urandom_range(2, 10);
    if (!keep_valid && $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: cnt = $urandom_range(0, 1);
        1: begin
          t  = lo;
          lo = hi;
          hi = t;
        end
        2: r  = $urandom_range(0, l);
        default: bt = $urandom_range(0, tp);
      endcase
    end
    smp_lo = lo;
    smp_hi = hi;
    ok = (cnt >= 2) && (hi > lo) && (r > l) && (bt > tp);
    cfg_write(REG_VMIN, lo[VAL_W-1:0]);
    cfg_write(REG_VMAX, hi[VAL_W-1:0]);
    cfg_write(REG_LEFT,   {8'($urandom), 8'(l)});
    cfg_write(REG_TOP,    {8'($urandom), 8'(tp)});
    cfg_write(REG_RIGHT,  {8'($urandom), 8'(r)});
    cfg_write(REG_BOTTOM, {8'($urandom), 8'(bt)});
    cfg_write(REG_COUNT,  {5'($urandom), 11'(cnt)});
    if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, 16'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_segs.size() == 0) begin
        flag_error("segment word with none expected");
      end else begin
        rx_want = pending_segs.pop_front();
        if (out_start_col !== rx_want.start_col)
          flag_error($sformatf("start_col %0d, want %0d", out_start_col, rx_want.start_col));
        if (out_start_row !== rx_want.start_row)
          flag_error($sformatf("start_row %0d, want %0d", out_start_row, rx_want.start_row));
        if (out_end_col !== rx_want.end_col)
          flag_error($sformatf("end_col %0d, want %0d", out_end_col, rx_want.end_col));
        if (out_end_row !== rx_want.end_row)
          flag_error($sformatf("end_row %0d, want %0d", out_end_row, rx_want.end_row));
        if (out_final_segment !== rx_want.final_seg)
          flag_error($sformatf("final_segment %0b, want %0b", out_final_segment,
                               rx_want.final_seg));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        stretch_left = $urandom_range(20, 80);
      end
      stretch_left--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (cyc_cnt % 5) != 0;
      endcase
    end
  end

  initial begin
    while (cyc_cnt < CYC_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("timeout after %0d cycles", cyc_cnt);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int rnd_cnt, phase, n, k, burst_left, t, spin;
    bit bursty, ok;
    logic [VAL_W-1:0] v;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_VMIN;
    cfg_data        = '0;
    plot_cfg        = '0;
    pt_idx          = '0;
    last_col        = '0;
    last_row        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (i > 0 && DIR_TAB[i-1].kind != ROW_CFG) settle();
        cfg_write(DIR_TAB[i].addr, DIR_TAB[i].data);
      end else begin
        send_sample(DIR_TAB[i].data, DIR_TAB[i].kind, DIR_TAB[i].seg);
      end
    end

    rnd_cnt = 0;
    phase   = 0;
    while (rnd_cnt < RND_ITEMS) begin
      settle();
      new_setup(phase == 2 || phase == 3, ok);
      n          = (phase == 2) ? 40 : $urandom_range(4, 40);
      bursty     = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 8);
      // output side backs up while samples keep coming
      if (phase == 2) hold_req = 1'b1;
      for (k = 0; k < n; k++) begin
        if (phase == 3 && k == n / 2) settle();
        t = $urandom_range(0, 19);
        if (t < 14 && smp_hi > smp_lo)
          v = VAL_W'(smp_lo + int'($urandom_range(0, smp_hi - smp_lo)));
        else if (t < 16) v = VAL_W'(smp_lo);
        else if (t < 18) v = VAL_W'(smp_hi);
        else             v = VAL_W'($urandom);
        send_sample(v, ROW_PRED, NO_SEG);
        if (ok) rnd_cnt++;
        if (bursty) begin
          burst_left--;
          if (burst_left == 0) begin
            in_gap($urandom_range(1, 6));
            burst_left = $urandom_range(1, 8);
          end
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    spin = 0;
    while (pending_segs.size() != 0 && spin < DRAIN_MAX) begin
      @(posedge clk);
      spin++;
    end
    repeat (IDLE_PAD) @(posedge clk);
    if (pending_segs.size() != 0)
      flag_error($sformatf("%0d segments never arrived", pending_segs.size()));
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/gps_pkg.sv
rtl/graph_polyline_scaler.sv
rtl/gps_checker.sv
test/tb_graph_polyline_scaler.sv
